### design/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CAP_W     = 7;
  localparam int OP_W      = 2;
  localparam int PRIO_W    = 16;
  localparam int PAY_W     = 32;
  localparam int ST_W      = 2;
  localparam int CNTO_W    = 7;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
  } cell_cmd_t;

endpackage
`default_nettype wire

### design/sorted_priority_queue.sv
`default_nettype none
// Sorted priority queue built as a row of DEPTH cells that compare and shift in parallel.
// One item is taken on every clock where start is high; busy is never raised. The result
// for an item appears on the out_ ports for one cycle, marked by out_valid, on the cycle
// after the item is taken, and cannot be stalled: a receiver must take it then. The
// result is registered alongside the cell row update. Entries of equal priority leave in
// arrival order. cfg_capacity limits the fill, clipped to DEPTH.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [PRIO_W-1:0] in_priority,
  input  wire logic [PAY_W-1:0]  in_payload,
  input  wire logic              cfg_we,
  input  wire logic [CAP_W-1:0]  cfg_capacity,
  output logic                   out_valid,
  output logic [ST_W-1:0]        out_status,
  output logic [PRIO_W-1:0]      out_priority,
  output logic [PAY_W-1:0]       out_payload,
  output logic [CNTO_W-1:0]      out_count_after
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              valid_r;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [PRIO_W-1:0] oprio_r, oprio_nxt;
  logic [PAY_W-1:0]  opay_r, opay_nxt;

  logic              accept, full, empty;
  logic [31:0]       limit;
  logic [31:0]       count_ext;
  cell_cmd_t         cmd;

  logic [PRIO_W-1:0] prio_w [DEPTH];
  logic [PAY_W-1:0]  pay_w  [DEPTH];
  logic              gt_w   [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign limit = (32'(cap_r) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cap_r);
  assign full  = 32'(count_r) >= limit;
  assign empty = count_r == '0;

  assign cmd.ins     = accept && (in_operation == OP_ENQ) && !full;
  assign cmd.pop     = accept && (in_operation == OP_DEQ) && !empty;
  assign cmd.prio    = in_priority;
  assign cmd.payload = in_payload;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    oprio_nxt  = '0;
    opay_nxt   = '0;
    case (in_operation)
      OP_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          oprio_nxt = prio_w[0];
          opay_nxt  = pay_w[0];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              l_gt;
    logic [PRIO_W-1:0] l_prio, r_prio;
    logic [PAY_W-1:0]  l_pay, r_pay;

    if (i == 0) begin : g_first
      assign l_gt   = 1'b0;
      assign l_prio = cmd.prio;
      assign l_pay  = cmd.payload;
    end else begin : g_mid
      assign l_gt   = gt_w[i-1];
      assign l_prio = prio_w[i-1];
      assign l_pay  = pay_w[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign r_prio = prio_w[i];
      assign r_pay  = pay_w[i];
    end else begin : g_inner
      assign r_prio = prio_w[i+1];
      assign r_pay  = pay_w[i+1];
    end

    spq_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .count        (count_r),
      .left_gt      (l_gt),
      .left_prio    (l_prio),
      .left_payload (l_pay),
      .right_prio   (r_prio),
      .right_payload(r_pay),
      .gt           (gt_w[i]),
      .prio         (prio_w[i]),
      .payload      (pay_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      oprio_r  <= oprio_nxt;
      opay_r   <= opay_nxt;
    end
  end

  assign count_ext       = 32'(count_r);
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_priority    = oprio_r;
  assign out_payload     = opay_r;
  assign out_count_after = count_ext[CNTO_W-1:0];

`ifndef SYNTHESIS
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("missing result for accepted item");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("entry count above depth");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_count_after == '0))
    else $error("empty status with nonzero count");

  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(count_r) >= 32'd2) |-> (prio_w[0] <= prio_w[1]))
    else $error("front entries out of order");
`endif

endmodule
`default_nettype wire

### design/spq_cell.sv
`default_nettype none
module spq_cell import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  wire logic                       clk,
  input  wire cell_cmd_t                  cmd,
  input  wire logic [$clog2(DEPTH+1)-1:0] count,
  input  wire logic                       left_gt,
  input  wire logic [PRIO_W-1:0]          left_prio,
  input  wire logic [PAY_W-1:0]           left_payload,
  input  wire logic [PRIO_W-1:0]          right_prio,
  input  wire logic [PAY_W-1:0]           right_payload,
  output logic                            gt,
  output logic [PRIO_W-1:0]               prio,
  output logic [PAY_W-1:0]                payload
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [PAY_W-1:0]  payload_r, payload_nxt;
  logic              occ;

  // occupied cells form a sorted prefix, so gt is a thermometer along the row
  assign occ = count > CNT_W'(IDX);
  assign gt  = !occ || (prio_r > cmd.prio);

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (cmd.pop) begin
      prio_nxt    = right_prio;
      payload_nxt = right_payload;
    end else if (cmd.ins && gt) begin
      if (left_gt) begin
        prio_nxt    = left_prio;
        payload_nxt = left_payload;
      end else begin
        prio_nxt    = cmd.prio;
        payload_nxt = cmd.payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule
`default_nettype wire
